### src/vfa_pkg.sv
`timescale 1ns / 1ps

package vfa_pkg;

	typedef logic [3:0] opcode_t;

	localparam opcode_t OP_ADD      = 4'd0;
	localparam opcode_t OP_SUB      = 4'd1;
	localparam opcode_t OP_CROSS    = 4'd2;
	localparam opcode_t OP_SCALE    = 4'd3;
	localparam opcode_t OP_DOT      = 4'd4;
	localparam opcode_t OP_TRIPLE   = 4'd5;
	localparam opcode_t OP_LENGTH   = 4'd6;
	localparam opcode_t OP_NORM     = 4'd7;
	localparam opcode_t OP_ZERO     = 4'd8;
	localparam opcode_t OP_PARALLEL = 4'd9;
	localparam opcode_t OP_PERP     = 4'd10;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_ZERO_LEN = 2'd1;
	localparam status_t ST_SAT      = 2'd2;

	// control that travels with a request down the pipeline
	typedef struct packed {
		opcode_t op;
		logic    test;
		logic    ov;
		logic    zlen;
	} ctl_t;

endpackage

### src/vfa_arith.sv
`timescale 1ns / 1ps

module vfa_arith import vfa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  opcode_t                     opcode,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	input  logic signed [WORD_BITS-1:0] c_x,
	input  logic signed [WORD_BITS-1:0] c_y,
	input  logic signed [WORD_BITS-1:0] c_z,
	input  logic signed [WORD_BITS-1:0] scale_factor,
	output logic                        out_vld,
	output ctl_t                        out_ctl,
	output logic [WORD_BITS-1:0]        out_x,
	output logic [WORD_BITS-1:0]        out_y,
	output logic [WORD_BITS-1:0]        out_z,
	output logic [WORD_BITS-1:0]        out_scalar,
	output logic [2*WORD_BITS-1:0]      out_rad,
	output logic [WORD_BITS-1:0]        out_mag_x,
	output logic [WORD_BITS-1:0]        out_mag_y,
	output logic [WORD_BITS-1:0]        out_mag_z,
	output logic [2:0]                  out_neg
);

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 2;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] HI = SW'(WMAX);
	localparam logic signed [SW-1:0] LO = SW'(WMIN);

	// {overflow, saturated word}
	function automatic logic [W:0] sat_word(input logic signed [SW-1:0] v);
		logic [W:0] r;
		if (v > HI) begin
			r = {1'b1, WMAX};
		end else if (v < LO) begin
			r = {1'b1, WMIN};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic signed [W-1:0] va [3];
	logic signed [W-1:0] vb [3];
	logic signed [W-1:0] vc [3];
	logic signed [W-1:0] ml [6];
	logic signed [W-1:0] mr [6];
	logic [W:0]          as_r [3];
	logic [W-1:0]        mag_r [3];

	always_comb begin
		va[0] = a_x; va[1] = a_y; va[2] = a_z;
		vb[0] = b_x; vb[1] = b_y; vb[2] = b_z;
		vc[0] = c_x; vc[1] = c_y; vc[2] = c_z;
		for (int i = 0; i < 6; i++) begin
			ml[i] = '0;
			mr[i] = '0;
		end
		case (opcode) inside
			OP_CROSS, OP_TRIPLE, OP_PARALLEL: begin
				ml[0] = va[1]; mr[0] = vb[2];
				ml[1] = va[2]; mr[1] = vb[1];
				ml[2] = va[2]; mr[2] = vb[0];
				ml[3] = va[0]; mr[3] = vb[2];
				ml[4] = va[0]; mr[4] = vb[1];
				ml[5] = va[1]; mr[5] = vb[0];
			end
			OP_SCALE: begin
				for (int k = 0; k < 3; k++) begin
					ml[2*k] = va[k];
					mr[2*k] = scale_factor;
				end
			end
			OP_DOT, OP_PERP: begin
				for (int k = 0; k < 3; k++) begin
					ml[2*k] = va[k];
					mr[2*k] = vb[k];
				end
			end
			OP_LENGTH, OP_NORM: begin
				for (int k = 0; k < 3; k++) begin
					ml[2*k] = va[k];
					mr[2*k] = va[k];
				end
			end
			default: ;
		endcase
		for (int k = 0; k < 3; k++) begin
			as_r[k] = sat_word((opcode == OP_SUB) ? SW'(va[k]) - SW'(vb[k])
				: SW'(va[k]) + SW'(vb[k]));
			mag_r[k] = va[k][W-1] ? (~va[k] + 1'b1) : va[k];
		end
	end

	// stage 1: products
	logic                 vld_s1;
	opcode_t              op_s1;
	logic signed [PW-1:0] m_s1 [6];
	logic [W:0]           as_s1 [3];
	logic signed [W-1:0]  c_s1 [3];
	logic                 az_s1, bz_s1;
	logic [W-1:0]         mag_s1 [3];
	logic [2:0]           neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		for (int i = 0; i < 6; i++) begin
			m_s1[i] <= PW'(ml[i]) * PW'(mr[i]);
		end
		for (int k = 0; k < 3; k++) begin
			as_s1[k]  <= as_r[k];
			c_s1[k]   <= vc[k];
			mag_s1[k] <= mag_r[k];
			neg_s1[k] <= va[k][W-1];
		end
		az_s1 <= (a_x == '0) && (a_y == '0) && (a_z == '0);
		bz_s1 <= (b_x == '0) && (b_y == '0) && (b_z == '0);
	end

	// stage 2: differences, sum, scale rescale
	logic                 vld_s2;
	opcode_t              op_s2;
	logic signed [SW-1:0] d_s2 [3];
	logic signed [SW-1:0] sum_s2;
	logic [W:0]           sc_s2 [3];
	logic                 pz_s2;
	logic [W:0]           as_s2 [3];
	logic signed [W-1:0]  c_s2 [3];
	logic                 az_s2, bz_s2;
	logic [W-1:0]         mag_s2 [3];
	logic [2:0]           neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		sum_s2 <= SW'(m_s1[0]) + SW'(m_s1[2]) + SW'(m_s1[4]);
		pz_s2  <= (m_s1[0] == m_s1[1]) && (m_s1[2] == m_s1[3]) && (m_s1[4] == m_s1[5]);
		for (int k = 0; k < 3; k++) begin
			d_s2[k]   <= SW'(m_s1[2*k]) - SW'(m_s1[2*k+1]);
			sc_s2[k]  <= sat_word(SW'(m_s1[2*k]) >>> FRAC_BITS);
			as_s2[k]  <= as_s1[k];
			c_s2[k]   <= c_s1[k];
			mag_s2[k] <= mag_s1[k];
		end
		az_s2  <= az_s1;
		bz_s2  <= bz_s1;
		neg_s2 <= neg_s1;
	end

	// stage 3: rescale and select
	logic [W:0]   xs [3];
	logic [W:0]   dt;
	ctl_t         ctl_n;
	logic [W-1:0] vec_n [3];
	logic [W-1:0] scal_n;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xs[k]    = sat_word(d_s2[k] >>> FRAC_BITS);
			vec_n[k] = '0;
		end
		dt         = sat_word(sum_s2 >>> FRAC_BITS);
		scal_n     = '0;
		ctl_n.op   = op_s2;
		ctl_n.test = 1'b0;
		ctl_n.ov   = 1'b0;
		ctl_n.zlen = 1'b0;
		case (op_s2) inside
			OP_ADD, OP_SUB: begin
				for (int k = 0; k < 3; k++) vec_n[k] = as_s2[k][W-1:0];
				ctl_n.ov = as_s2[0][W] | as_s2[1][W] | as_s2[2][W];
			end
			OP_SCALE: begin
				for (int k = 0; k < 3; k++) vec_n[k] = sc_s2[k][W-1:0];
				ctl_n.ov = sc_s2[0][W] | sc_s2[1][W] | sc_s2[2][W];
			end
			OP_CROSS: begin
				for (int k = 0; k < 3; k++) vec_n[k] = xs[k][W-1:0];
				ctl_n.ov = xs[0][W] | xs[1][W] | xs[2][W];
			end
			OP_DOT: begin
				scal_n   = dt[W-1:0];
				ctl_n.ov = dt[W];
			end
			OP_TRIPLE: begin
				ctl_n.ov = xs[0][W] | xs[1][W] | xs[2][W];
			end
			OP_ZERO: begin
				ctl_n.test = az_s2;
			end
			OP_PARALLEL: begin
				if (az_s2 || bz_s2) ctl_n.zlen = 1'b1;
				else ctl_n.test = pz_s2;
			end
			OP_PERP: begin
				if (az_s2 || bz_s2) ctl_n.zlen = 1'b1;
				else ctl_n.test = (sum_s2 == '0);
			end
			default: ;
		endcase
	end

	logic                vld_s3;
	ctl_t                ctl_s3;
	logic [W-1:0]        vec_s3 [3];
	logic [W-1:0]        scal_s3;
	logic signed [W-1:0] x_s3 [3];
	logic signed [W-1:0] c_s3 [3];
	logic [PW-1:0]       rad_s3;
	logic [W-1:0]        mag_s3 [3];
	logic [2:0]          neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3  <= ctl_n;
		scal_s3 <= scal_n;
		rad_s3  <= sum_s2[PW-1:0];
		neg_s3  <= neg_s2;
		for (int k = 0; k < 3; k++) begin
			vec_s3[k] <= vec_n[k];
			x_s3[k]   <= xs[k][W-1:0];
			c_s3[k]   <= c_s2[k];
			mag_s3[k] <= mag_s2[k];
		end
	end

	// stage 4: triple product terms
	logic                 vld_s4;
	ctl_t                 ctl_s4;
	logic [W-1:0]         vec_s4 [3];
	logic [W-1:0]         scal_s4;
	logic signed [PW-1:0] tp_s4 [3];
	logic [PW-1:0]        rad_s4;
	logic [W-1:0]         mag_s4 [3];
	logic [2:0]           neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4  <= ctl_s3;
		scal_s4 <= scal_s3;
		rad_s4  <= rad_s3;
		neg_s4  <= neg_s3;
		for (int k = 0; k < 3; k++) begin
			vec_s4[k] <= vec_s3[k];
			tp_s4[k]  <= PW'(x_s3[k]) * PW'(c_s3[k]);
			mag_s4[k] <= mag_s3[k];
		end
	end

	// stage 5: triple sum
	logic                 vld_s5;
	ctl_t                 ctl_s5;
	logic [W-1:0]         vec_s5 [3];
	logic [W-1:0]         scal_s5;
	logic signed [SW-1:0] ts_s5;
	logic [PW-1:0]        rad_s5;
	logic [W-1:0]         mag_s5 [3];
	logic [2:0]           neg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s5  <= ctl_s4;
		scal_s5 <= scal_s4;
		ts_s5   <= SW'(tp_s4[0]) + SW'(tp_s4[1]) + SW'(tp_s4[2]);
		rad_s5  <= rad_s4;
		neg_s5  <= neg_s4;
		for (int k = 0; k < 3; k++) begin
			vec_s5[k] <= vec_s4[k];
			mag_s5[k] <= mag_s4[k];
		end
	end

	// stage 6: triple rescale
	logic [W:0]   tt;
	ctl_t         ctl_t6;
	logic [W-1:0] scal_t6;

	always_comb begin
		tt      = sat_word(ts_s5 >>> FRAC_BITS);
		ctl_t6  = ctl_s5;
		scal_t6 = scal_s5;
		if (ctl_s5.op == OP_TRIPLE) begin
			scal_t6   = tt[W-1:0];
			ctl_t6.ov = ctl_s5.ov | tt[W];
		end
	end

	logic          vld_s6;
	ctl_t          ctl_s6;
	logic [W-1:0]  vec_s6 [3];
	logic [W-1:0]  scal_s6;
	logic [PW-1:0] rad_s6;
	logic [W-1:0]  mag_s6 [3];
	logic [2:0]    neg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s6  <= ctl_t6;
		scal_s6 <= scal_t6;
		rad_s6  <= rad_s5;
		neg_s6  <= neg_s5;
		for (int k = 0; k < 3; k++) begin
			vec_s6[k] <= vec_s5[k];
			mag_s6[k] <= mag_s5[k];
		end
	end

	assign out_vld    = vld_s6;
	assign out_ctl    = ctl_s6;
	assign out_x      = vec_s6[0];
	assign out_y      = vec_s6[1];
	assign out_z      = vec_s6[2];
	assign out_scalar = scal_s6;
	assign out_rad    = rad_s6;
	assign out_mag_x  = mag_s6[0];
	assign out_mag_y  = mag_s6[1];
	assign out_mag_z  = mag_s6[2];
	assign out_neg    = neg_s6;

endmodule

### src/vfa_sqrt.sv
`timescale 1ns / 1ps

module vfa_sqrt import vfa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int PAY_BITS  = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic [2*WORD_BITS-1:0] in_rad,
	input  logic [PAY_BITS-1:0]    in_pay,
	output logic                   out_vld,
	output logic [WORD_BITS-1:0]   out_root,
	output logic [PAY_BITS-1:0]    out_pay
);

	localparam int W = WORD_BITS;

	// one root bit per stage, two radicand bits consumed per stage
	logic [W+1:0]        rem_s  [W];
	logic [W-1:0]        root_s [W];
	logic [2*W-1:0]      rad_s  [W];
	logic [PAY_BITS-1:0] pay_s  [W];
	logic [W-1:0]        vld_s;

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W+1:0]        rem_i;
		logic [W-1:0]        root_i;
		logic [2*W-1:0]      rad_i;
		logic [PAY_BITS-1:0] pay_i;
		logic                vld_i;
		logic [W+1:0]        sh;
		logic [W+1:0]        trial;
		logic                ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = in_rad;
			assign pay_i  = in_pay;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign pay_i  = pay_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign sh    = {rem_i[W-1:0], rad_i[2*W-1:2*W-2]};
		assign trial = {root_i, 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? (sh - trial) : sh;
			root_s[k] <= {root_i[W-2:0], ge};
			rad_s[k]  <= {rad_i[2*W-3:0], 2'b00};
			pay_s[k]  <= pay_i;
		end
	end

	assign out_vld  = vld_s[W-1];
	assign out_root = root_s[W-1];
	assign out_pay  = pay_s[W-1];

endmodule

### src/vfa_div.sv
`timescale 1ns / 1ps

module vfa_div import vfa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	parameter int PAY_BITS  = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [WORD_BITS-1:0]        in_den,
	input  logic [2:0][WORD_BITS-1:0]   in_mag,
	input  logic [PAY_BITS-1:0]         in_pay,
	output logic                        out_vld,
	output logic [WORD_BITS-1:0]        out_den,
	output logic [2:0][FRAC_BITS:0]     out_quo,
	output logic [PAY_BITS-1:0]         out_pay
);

	localparam int W  = WORD_BITS;
	localparam int NS = FRAC_BITS + 1;

	// three restoring dividers in lockstep, one quotient bit per stage;
	// magnitude never exceeds the divisor, so the quotient fits FRAC_BITS+1 bits
	logic [2:0][W:0]         rem_s [NS];
	logic [2:0][FRAC_BITS:0] quo_s [NS];
	logic [W-1:0]            den_s [NS];
	logic [PAY_BITS-1:0]     pay_s [NS];
	logic [NS-1:0]           vld_s;

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [2:0][W:0]         sh;
		logic [2:0][FRAC_BITS:0] quo_i;
		logic [W-1:0]            den_i;
		logic [PAY_BITS-1:0]     pay_i;
		logic                    vld_i;
		logic [2:0][W:0]         rem_n;
		logic [2:0][FRAC_BITS:0] quo_n;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					sh[l]    = {1'b0, in_mag[l]};
					quo_i[l] = '0;
				end
			end
			assign den_i = in_den;
			assign pay_i = in_pay;
			assign vld_i = in_vld;
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					sh[l]    = {rem_s[k-1][l][W-1:0], 1'b0};
					quo_i[l] = quo_s[k-1][l];
				end
			end
			assign den_i = den_s[k-1];
			assign pay_i = pay_s[k-1];
			assign vld_i = vld_s[k-1];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (sh[l] >= {1'b0, den_i}) begin
					rem_n[l] = sh[l] - {1'b0, den_i};
					quo_n[l] = {quo_i[l][FRAC_BITS-1:0], 1'b1};
				end else begin
					rem_n[l] = sh[l];
					quo_n[l] = {quo_i[l][FRAC_BITS-1:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_n;
			quo_s[k] <= quo_n;
			den_s[k] <= den_i;
			pay_s[k] <= pay_i;
		end
	end

	assign out_vld = vld_s[NS-1];
	assign out_den = den_s[NS-1];
	assign out_quo = quo_s[NS-1];
	assign out_pay = pay_s[NS-1];

endmodule

### src/vector3_fixed_point_alu_core.sv
`timescale 1ns / 1ps

// channel   | handshake         | payload
// ----------+-------------------+---------------------------------------------
// request   | start, busy       | opcode, a_*, b_*, c_*, scale_factor
// result    | done (one cycle)  | res_x, res_y, res_z, res_scalar, test_true, status
//
// one request may enter every cycle; busy stays low
// the path is six arithmetic stages, one square root stage per root bit, one
// divide stage per quotient bit and the output register; every opcode takes the
// same path so order is kept
// arst_n clears all valid bits; results are never held off by the receiver

module vector3_fixed_point_alu_core import vfa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [3:0]                  opcode,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	input  logic signed [WORD_BITS-1:0] c_x,
	input  logic signed [WORD_BITS-1:0] c_y,
	input  logic signed [WORD_BITS-1:0] c_z,
	input  logic signed [WORD_BITS-1:0] scale_factor,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] res_x,
	output logic signed [WORD_BITS-1:0] res_y,
	output logic signed [WORD_BITS-1:0] res_z,
	output logic signed [WORD_BITS-1:0] res_scalar,
	output logic                        test_true,
	output logic [1:0]                  status
);

	localparam int W    = WORD_BITS;
	localparam int CB   = $bits(ctl_t);
	localparam int PB1  = CB + 7 * W + 3;
	localparam int PB2  = CB + 4 * W + 3;
	localparam int QW   = W + FRAC_BITS + 2;
	localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [QW-1:0] QMAX = QW'(WMAX);
	localparam logic signed [QW-1:0] QMIN = QW'(WMIN);

	assign busy = 1'b0;

	// front arithmetic
	logic           ar_vld;
	ctl_t           ar_ctl;
	logic [W-1:0]   ar_x, ar_y, ar_z, ar_sc;
	logic [2*W-1:0] ar_rad;
	logic [W-1:0]   ar_mx, ar_my, ar_mz;
	logic [2:0]     ar_neg;

	vfa_arith #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (start),
		.opcode       (opcode),
		.a_x          (a_x),
		.a_y          (a_y),
		.a_z          (a_z),
		.b_x          (b_x),
		.b_y          (b_y),
		.b_z          (b_z),
		.c_x          (c_x),
		.c_y          (c_y),
		.c_z          (c_z),
		.scale_factor (scale_factor),
		.out_vld      (ar_vld),
		.out_ctl      (ar_ctl),
		.out_x        (ar_x),
		.out_y        (ar_y),
		.out_z        (ar_z),
		.out_scalar   (ar_sc),
		.out_rad      (ar_rad),
		.out_mag_x    (ar_mx),
		.out_mag_y    (ar_my),
		.out_mag_z    (ar_mz),
		.out_neg      (ar_neg)
	);

	// square root of the sum of squares
	logic           sq_vld;
	logic [W-1:0]   sq_root;
	logic [PB1-1:0] sq_pay;
	ctl_t           sq_ctl;
	logic [W-1:0]   sq_x, sq_y, sq_z, sq_sc, sq_mx, sq_my, sq_mz;
	logic [2:0]     sq_neg;

	vfa_sqrt #(
		.WORD_BITS(WORD_BITS),
		.PAY_BITS (PB1)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (ar_vld),
		.in_rad   (ar_rad),
		.in_pay   ({ar_ctl, ar_x, ar_y, ar_z, ar_sc, ar_mx, ar_my, ar_mz, ar_neg}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_pay  (sq_pay)
	);

	assign {sq_ctl, sq_x, sq_y, sq_z, sq_sc, sq_mx, sq_my, sq_mz, sq_neg} = sq_pay;

	// normalise: magnitude over length
	logic                    dv_vld;
	logic [W-1:0]            dv_den;
	logic [2:0][FRAC_BITS:0] dv_quo;
	logic [PB2-1:0]          dv_pay;
	ctl_t                    dv_ctl;
	logic [W-1:0]            dv_x, dv_y, dv_z, dv_sc;
	logic [2:0]              dv_neg;

	vfa_div #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS),
		.PAY_BITS (PB2)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.in_den  (sq_root),
		.in_mag  ({sq_mz, sq_my, sq_mx}),
		.in_pay  ({sq_ctl, sq_x, sq_y, sq_z, sq_sc, sq_neg}),
		.out_vld (dv_vld),
		.out_den (dv_den),
		.out_quo (dv_quo),
		.out_pay (dv_pay)
	);

	assign {dv_ctl, dv_x, dv_y, dv_z, dv_sc, dv_neg} = dv_pay;

	// final select
	ctl_t                fc;
	logic [W-1:0]        fv [3];
	logic [W-1:0]        fs;
	logic signed [QW-1:0] qs;
	status_t             fst;

	always_comb begin
		fc    = dv_ctl;
		fv[0] = dv_x;
		fv[1] = dv_y;
		fv[2] = dv_z;
		fs    = dv_sc;
		qs    = '0;
		if (dv_ctl.op == OP_LENGTH) begin
			if (dv_den > WMAX_U) begin
				fs    = WMAX_U;
				fc.ov = 1'b1;
			end else begin
				fs = dv_den;
			end
		end
		if (dv_ctl.op == OP_NORM) begin
			if (dv_den == '0) begin
				fc.zlen = 1'b1;
			end else begin
				for (int k = 0; k < 3; k++) begin
					qs = signed'(QW'(dv_quo[k]));
					if (dv_neg[k]) qs = -qs;
					if (qs > QMAX) begin
						fv[k] = WMAX;
						fc.ov = 1'b1;
					end else if (qs < QMIN) begin
						fv[k] = WMIN;
						fc.ov = 1'b1;
					end else begin
						fv[k] = qs[W-1:0];
					end
				end
			end
		end
		if (fc.zlen) fst = ST_ZERO_LEN;
		else if (fc.ov) fst = ST_SAT;
		else fst = ST_OK;
	end

	logic         done_q;
	logic [W-1:0] res_x_q, res_y_q, res_z_q, res_sc_q;
	logic         test_q;
	status_t      status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_x_q  <= fv[0];
		res_y_q  <= fv[1];
		res_z_q  <= fv[2];
		res_sc_q <= fs;
		test_q   <= fc.test;
		status_q <= fst;
	end

	assign done       = done_q;
	assign res_x      = res_x_q;
	assign res_y      = res_y_q;
	assign res_z      = res_z_q;
	assign res_scalar = res_sc_q;
	assign test_true  = test_q;
	assign status     = status_q;

	a_zero_len_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ZERO_LEN |-> !test_true && res_x == '0 && res_y == '0
			&& res_z == '0 && res_scalar == '0)
		else $error("zero-length result carries data");

	a_pred_no_vec: assert property (@(posedge clk) disable iff (!arst_n)
		done && test_true |-> res_x == '0 && res_y == '0 && res_z == '0
			&& res_scalar == '0 && status == ST_OK)
		else $error("predicate result carries data or bad status");

	a_sat_no_pred: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SAT |-> !test_true)
		else $error("saturated result with predicate set");

endmodule

### tb/sv/vector3_fixed_point_alu_checker.sv
`timescale 1ns / 1ps

module vector3_fixed_point_alu_checker import vfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] c_x,
	input  logic signed [31:0] c_y,
	input  logic signed [31:0] c_z,
	input  logic signed [31:0] scale_factor,
	input  logic               done,
	input  logic signed [31:0] res_x,
	input  logic signed [31:0] res_y,
	input  logic signed [31:0] res_z,
	input  logic signed [31:0] res_scalar,
	input  logic               test_true,
	input  logic [1:0]         status,
	output int                 errors,
	output int                 pending
);

	localparam int FRAC = 16;

	typedef logic signed [31:0] word_t;
	typedef logic signed [127:0] wide_t;
	typedef word_t vec_t [0:2];

	typedef struct {
		word_t   x;
		word_t   y;
		word_t   z;
		word_t   scalar;
		logic    pred;
		status_t st;
	} alu_result_t;

	alu_result_t result_q[$];

	function automatic wide_t widen(input word_t v);
		wide_t r;
		r = v;
		return r;
	endfunction

	function automatic word_t clamp(input wide_t v, inout logic ov);
		wide_t hi, lo;
		hi = 128'sd2147483647;
		lo = -128'sd2147483648;
		if (v > hi) begin
			ov = 1'b1;
			return hi[31:0];
		end
		if (v < lo) begin
			ov = 1'b1;
			return lo[31:0];
		end
		return v[31:0];
	endfunction

	function automatic word_t cross_term(input word_t x1, y2, x2, y1, inout logic ov,
			output logic zero);
		wide_t p0, p1;
		p0 = widen(x1) * widen(y2);
		p1 = widen(x2) * widen(y1);
		zero = (p0 == p1);
		return clamp((p0 - p1) >>> FRAC, ov);
	endfunction

	function automatic logic cross_vec(input vec_t a, b, output vec_t r, inout logic ov);
		logic z0, z1, z2;
		r[0] = cross_term(a[1], b[2], a[2], b[1], ov, z0);
		r[1] = cross_term(a[2], b[0], a[0], b[2], ov, z1);
		r[2] = cross_term(a[0], b[1], a[1], b[0], ov, z2);
		return z0 && z1 && z2;
	endfunction

	function automatic word_t dot_vec(input vec_t a, b, inout logic ov, output logic zero);
		wide_t sum;
		sum = widen(a[0]) * widen(b[0]) + widen(a[1]) * widen(b[1])
			+ widen(a[2]) * widen(b[2]);
		zero = (sum == 0);
		return clamp(sum >>> FRAC, ov);
	endfunction

	function automatic logic [127:0] magnitude(input vec_t a);
		logic [127:0] s, cc;
		logic [63:0] r;
		s = 0;
		for (int i = 0; i < 3; i++)
			s = s + 128'(widen(a[i]) * widen(a[i]));
		r = 0;
		for (int bit_i = 63; bit_i >= 0; bit_i--) begin
			cc = 128'(r | (64'd1 << bit_i));
			if (cc * cc <= s)
				r = r | (64'd1 << bit_i);
		end
		return 128'(r);
	endfunction

	function automatic logic all_zero(input vec_t a);
		return a[0] == 0 && a[1] == 0 && a[2] == 0;
	endfunction

	function automatic alu_result_t compute(input opcode_t op, input vec_t a, b, c,
			input word_t sf);
		alu_result_t r;
		vec_t v, x;
		logic ov, z;
		logic [127:0] len, num, q;
		wide_t sq;
		r = '{x: 0, y: 0, z: 0, scalar: 0, pred: 1'b0, st: ST_OK};
		v = '{0, 0, 0};
		ov = 1'b0;
		case (op)
			OP_ADD: for (int i = 0; i < 3; i++) v[i] = clamp(widen(a[i]) + widen(b[i]), ov);
			OP_SUB: for (int i = 0; i < 3; i++) v[i] = clamp(widen(a[i]) - widen(b[i]), ov);
			OP_CROSS: z = cross_vec(a, b, v, ov);
			OP_SCALE: for (int i = 0; i < 3; i++)
				v[i] = clamp((widen(a[i]) * widen(sf)) >>> FRAC, ov);
			OP_DOT: r.scalar = dot_vec(a, b, ov, z);
			OP_TRIPLE: begin
				z = cross_vec(a, b, x, ov);
				r.scalar = dot_vec(x, c, ov, z);
			end
			OP_LENGTH: r.scalar = clamp(wide_t'(magnitude(a)), ov);
			OP_NORM: begin
				len = magnitude(a);
				if (len == 0)
					r.st = ST_ZERO_LEN;
				else
					for (int i = 0; i < 3; i++) begin
						num = 128'(a[i] < 0 ? -widen(a[i]) : widen(a[i])) << FRAC;
						q = num / len;
						sq = a[i] < 0 ? -wide_t'(q) : wide_t'(q);
						v[i] = clamp(sq, ov);
					end
			end
			OP_ZERO: r.pred = all_zero(a);
			OP_PARALLEL: begin
				if (all_zero(a) || all_zero(b))
					r.st = ST_ZERO_LEN;
				else
					r.pred = cross_vec(a, b, x, z);
			end
			OP_PERP: begin
				if (all_zero(a) || all_zero(b))
					r.st = ST_ZERO_LEN;
				else begin
					x[0] = dot_vec(a, b, z, r.pred);
				end
			end
			default: ;
		endcase
		r.x = v[0];
		r.y = v[1];
		r.z = v[2];
		if (ov && r.st == ST_OK)
			r.st = ST_SAT;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n) begin
			if (done) begin
				if (result_q.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (res_x !== want.x) report("res_x", res_x, want.x);
					if (res_y !== want.y) report("res_y", res_y, want.y);
					if (res_z !== want.z) report("res_z", res_z, want.z);
					if (res_scalar !== want.scalar)
						report("res_scalar", res_scalar, want.scalar);
					if (test_true !== want.pred) report("test_true", test_true, want.pred);
					if (status !== want.st) report("status", status, want.st);
				end
			end
			if (start && !busy)
				result_q.push_back(compute(opcode, '{a_x, a_y, a_z}, '{b_x, b_y, b_z},
					'{c_x, c_y, c_z}, scale_factor));
			pending = result_q.size();
		end
	end

endmodule

### tb/sv/vector3_fixed_point_alu_core_tb.sv
`timescale 1ns / 1ps

module vector3_fixed_point_alu_core_tb import vfa_pkg::*;;

	localparam logic signed [31:0] WMAX = 32'sh7fffffff;
	localparam logic signed [31:0] WMIN = 32'sh80000000;
	localparam logic signed [31:0] ONE  = 32'sh00010000;

	typedef logic signed [31:0] word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] opcode = '0;
	word_t a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	word_t c_x = 0, c_y = 0, c_z = 0, scale_factor = 0;
	logic done, test_true;
	word_t res_x, res_y, res_z, res_scalar;
	logic [1:0] status;
	int errors, pending;
	int idle_pct;

	vector3_fixed_point_alu_core dut (.*);

	vector3_fixed_point_alu_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic issue(input opcode_t op, input word_t ax, ay, az, bx, by, bz,
			input word_t cx, cy, cz, sf);
		opcode <= op;
		a_x <= ax; a_y <= ay; a_z <= az;
		b_x <= bx; b_y <= by; b_z <= bz;
		c_x <= cx; c_y <= cy; c_z <= cz;
		scale_factor <= sf;
		start <= 1'b1;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic word_t any_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return word_t'($urandom_range(0, 1 << 21)) - (1 << 20);
			2: return word_t'($urandom_range(0, 1 << 25)) - (1 << 24);
			3: case ($urandom_range(5))
				0: return 0;
				1: return WMAX;
				2: return WMIN;
				3: return -1;
				4: return ONE;
				default: return -ONE;
			endcase
			default: return word_t'($urandom_range(0, 1 << 17)) - (1 << 16);
		endcase
	endfunction

	task automatic random_request();
		opcode_t op;
		word_t ax, ay, az, bx, by, bz, k;
		op = $urandom_range(15) < 14 ? opcode_t'($urandom_range(10)) : opcode_t'($urandom);
		ax = any_word(); ay = any_word(); az = any_word();
		bx = any_word(); by = any_word(); bz = any_word();
		if ($urandom_range(9) == 0) begin
			ax = 0; ay = 0; az = 0;
		end
		if ((op == OP_PARALLEL || op == OP_PERP) && $urandom_range(9) == 1) begin
			bx = 0; by = 0; bz = 0;
		end
		if (op == OP_PARALLEL && $urandom_range(1)) begin
			ax = ax >>> 12; ay = ay >>> 12; az = az >>> 12;
			k = $urandom_range(0, 200) - 100;
			bx = ax * k; by = ay * k; bz = az * k;
		end
		if (op == OP_PERP && $urandom_range(1)) begin
			bx = -ay; by = ax; bz = 0;
			az = 0;
		end
		issue(op, ax, ay, az, bx, by, bz, any_word(), any_word(), any_word(), any_word());
	endtask

	initial begin
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests
		issue(OP_ADD, WMAX, WMIN, ONE, ONE, -1, ONE, 0, 0, 0, 0);
		issue(OP_SUB, WMIN, WMAX, 5, ONE, -1, 7, 0, 0, 0, 0);
		issue(OP_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0, 0, 0, 0);
		issue(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0);
		issue(OP_SCALE, WMAX, WMIN, -3, 0, 0, 0, 0, 0, 0, WMIN);
		issue(OP_SCALE, ONE, -ONE, 3, 0, 0, 0, 0, 0, 0, ONE / 2);
		issue(OP_DOT, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0);
		issue(OP_DOT, -1, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		issue(OP_TRIPLE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		issue(OP_TRIPLE, WMAX, WMIN, WMAX, WMIN, WMAX, WMAX, WMAX, WMAX, WMIN, 0);
		issue(OP_LENGTH, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_LENGTH, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_NORM, WMIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_NORM, -3, 4, WMAX, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_ZERO, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_PARALLEL, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
		issue(OP_PARALLEL, 1, 2, 3, -2, -4, -6, 0, 0, 0, 0);
		issue(OP_PERP, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_PERP, 1, 2, 0, -2, 1, WMAX, 0, 0, 0, 0);
		issue(OP_PERP, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0);
		issue(opcode_t'(11), 1, 2, 3, 4, 5, 6, 7, 8, 9, 10);
		issue(opcode_t'(15), WMIN, WMAX, -1, -1, -1, -1, -1, -1, -1, -1);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = phase == 0 ? 0 : phase == 1 ? 85 : phase == 2 ? 0 : 25;
			repeat (345) random_request();
			if (phase == 1) begin
				start <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### vector3_fixed_point_alu_core.f
src/vfa_pkg.sv
src/vfa_arith.sv
src/vfa_sqrt.sv
src/vfa_div.sv
src/vector3_fixed_point_alu_core.sv
tb/sv/vector3_fixed_point_alu_checker.sv
tb/sv/vector3_fixed_point_alu_core_tb.sv
